>>> rtl/asm_pkg.sv
// asm_pkg: shared types, constants and codes for the anchored sequence merge
// used by asm_scan_unit, asm_seq and anchored_sequence_merge_core
// no dependencies
package asm_pkg;

  localparam int MAX_LEN = 32;
  localparam int VAL_W   = 31;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int N_W     = CNT_W + 1;

  typedef enum logic [1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_APPEND_ANCHOR = 2'd2,
    OP_RUN           = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISSING  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_FIRST,
    S_SCAN_SECOND,
    S_PUT_ANCHOR,
    S_TAIL_FIRST,
    S_TAIL_SECOND,
    S_SINGLE
  } state_e;

  // element taken from the list under scan and its match against the anchor
  typedef struct packed {
    logic [VAL_W-1:0] elem;
    logic             hit;
  } scan_t;

  // write port control for the three list memories
  typedef struct packed {
    logic              we_first;
    logic              we_second;
    logic              we_anchor;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } wr_t;

  // one result item handed to the output register
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
    logic             last;
    status_e          status;
    logic             empty;
  } emit_t;

endpackage

>>> rtl/anchored_sequence_merge_core.sv
// anchored_sequence_merge_core: top level of the anchored sequence merge
// depends on asm_pkg, asm_ram, asm_scan_unit and asm_seq
//
// Three lists of 31-bit values (first, second, anchor; up to MAX_LEN = 32
// each) are loaded one element per transfer with op 0, 1 or 2; a load gives
// no result of its own, and a load into a full list is dropped and
// remembered as an overflow. A transfer with op 3 runs the merge: for each
// anchor, the first-list elements before its next match, then the same in the
// second list, then the anchor; after the last anchor the rest of the first
// list and then the rest of the second. Results leave one per transfer with
// last set on the final one. A pending overflow gives a single item with
// status 2, an anchor missing from either list a single item with status 1,
// and an empty merge a single item with empty_res set. Every run clears all
// lists and the overflow flag. Each list sits in its own memory, and a single
// compare unit checks one element per cycle against the current anchor while
// the output side keeps up. A run with anchors walks the lists twice: a check
// pass that only confirms every anchor is found, visiting elements only as
// far as the last anchor's match in each list, then an emit pass that visits
// each list element once (emitted or skipped as an anchor match), each anchor
// once and moves on from the first tail to the second when the first list
// ends (fc, sc, ac: list lengths); it yields fc + sc - ac results. A missing
// anchor cuts the check short and ends with its single item; an overflow run
// or an empty merge gives just its single item. New input is taken only
// between runs.
module anchored_sequence_merge_core import asm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       op_i,
  input  logic [VAL_W-1:0] value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [VAL_W-1:0] value_res_o,
  output logic             last_o,
  output logic [1:0]       status_o,
  output logic             empty_res_o
);

  wr_t               wr;
  emit_t             emit;
  scan_t             scan;
  logic [ADDR_W-1:0] first_raddr, second_raddr, anchor_raddr;
  logic [VAL_W-1:0]  first_data, second_data, anchor_data;
  logic              scan_second;
  logic              slot_free;

  // result register
  logic              out_valid_q;
  logic [VAL_W-1:0]  value_q;
  logic              last_q;
  status_e           status_q;
  logic              empty_q;

  // the result register can take a new item when empty or being drained
  assign slot_free = !out_valid_q || out_ready_i;

  // list memories, read address follows the next pointer so the read
  // data always matches the current pointer
  asm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN), .AW(ADDR_W)) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (wr.we_first),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (first_raddr),
    .rdata_o (first_data)
  );

  asm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN), .AW(ADDR_W)) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (wr.we_second),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (second_raddr),
    .rdata_o (second_data)
  );

  asm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN), .AW(ADDR_W)) u_anchor_ram (
    .clk_i   (clk_i),
    .we_i    (wr.we_anchor),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (anchor_raddr),
    .rdata_o (anchor_data)
  );

  // shared element select and anchor compare
  asm_scan_unit u_scan (
    .first_data_i  (first_data),
    .second_data_i (second_data),
    .anchor_data_i (anchor_data),
    .sel_second_i  (scan_second),
    .scan_o        (scan)
  );

  // sequencer: loads, check pass, emit pass
  asm_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .value_i        (value_i),
    .scan_i         (scan),
    .anchor_data_i  (anchor_data),
    .slot_free_i    (slot_free),
    .wr_o           (wr),
    .first_raddr_o  (first_raddr),
    .second_raddr_o (second_raddr),
    .anchor_raddr_o (anchor_raddr),
    .scan_second_o  (scan_second),
    .emit_o         (emit)
  );

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload, loaded only when a new item is emitted
  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      value_q  <= emit.value;
      last_q   <= emit.last;
      status_q <= emit.status;
      empty_q  <= emit.empty;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_res_o = value_q;
  assign last_o      = last_q;
  assign status_o    = status_q;
  assign empty_res_o = empty_q;

endmodule

>>> rtl/asm_ram.sv
// asm_ram: generic single write port, single read port memory
// read data is registered; no dependencies
module asm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/asm_scan_unit.sv
// asm_scan_unit: shared element select and anchor compare
// depends on asm_pkg
module asm_scan_unit import asm_pkg::*; (
  input  logic [VAL_W-1:0] first_data_i,
  input  logic [VAL_W-1:0] second_data_i,
  input  logic [VAL_W-1:0] anchor_data_i,
  input  logic             sel_second_i,
  output scan_t            scan_o
);

  logic [VAL_W-1:0] elem;

  assign elem        = sel_second_i ? second_data_i : first_data_i;
  assign scan_o.elem = elem;
  assign scan_o.hit  = (elem == anchor_data_i);

endmodule

>>> rtl/asm_seq.sv
// asm_seq: load counters, list pointers and the run sequencer
// depends on asm_pkg; drives the list memories and the result register
module asm_seq import asm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [VAL_W-1:0]  value_i,
  input  scan_t             scan_i,
  input  logic [VAL_W-1:0]  anchor_data_i,
  input  logic              slot_free_i,
  output wr_t               wr_o,
  output logic [ADDR_W-1:0] first_raddr_o,
  output logic [ADDR_W-1:0] second_raddr_o,
  output logic [ADDR_W-1:0] anchor_raddr_o,
  output logic              scan_second_o,
  output emit_t             emit_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  fc_q, fc_d, sc_q, sc_d, ac_q, ac_d;
  logic [CNT_W-1:0]  i_q, i_d, j_q, j_d, z_q, z_d;
  logic [N_W-1:0]    outcnt_q, outcnt_d;
  logic              ovf_q, ovf_d;
  logic              emit_pass_q, emit_pass_d;
  status_e           st_q, st_d;

  op_e               op;
  logic              accept;
  logic              end_first, end_second, last_anchor, go, last_item;
  logic [N_W-1:0]    total;

  assign op          = op_e'(op_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign end_first   = (i_q >= fc_q);
  assign end_second  = (j_q >= sc_q);
  assign last_anchor = (CNT_W'(z_q + 1'b1) == ac_q);
  assign go          = !emit_pass_q || slot_free_i;
  assign total       = N_W'(fc_q) + N_W'(sc_q) - N_W'(ac_q);
  assign last_item   = (outcnt_q == (total - N_W'(1)));

  assign scan_second_o  = (state_q == S_SCAN_SECOND) || (state_q == S_TAIL_SECOND);
  assign first_raddr_o  = i_d[ADDR_W-1:0];
  assign second_raddr_o = j_d[ADDR_W-1:0];
  assign anchor_raddr_o = z_d[ADDR_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (op == OP_RUN)) begin
          if (ovf_q) begin
            state_d = S_SINGLE;
          end else if (ac_q != '0) begin
            state_d = S_SCAN_FIRST;
          end else if ((fc_q == '0) && (sc_q == '0)) begin
            state_d = S_SINGLE;
          end else begin
            state_d = S_TAIL_FIRST;
          end
        end
      end
      S_SCAN_FIRST: begin
        if (end_first) begin
          state_d = S_SINGLE;
        end else if (scan_i.hit) begin
          state_d = S_SCAN_SECOND;
        end
      end
      S_SCAN_SECOND: begin
        if (end_second) begin
          state_d = S_SINGLE;
        end else if (scan_i.hit) begin
          state_d = emit_pass_q ? S_PUT_ANCHOR : S_SCAN_FIRST;
        end
      end
      S_PUT_ANCHOR: begin
        if (slot_free_i) begin
          if (last_item) begin
            state_d = S_IDLE;
          end else if (last_anchor) begin
            state_d = S_TAIL_FIRST;
          end else begin
            state_d = S_SCAN_FIRST;
          end
        end
      end
      S_TAIL_FIRST: begin
        if (end_first) begin
          state_d = S_TAIL_SECOND;
        end else if (slot_free_i && last_item) begin
          state_d = S_IDLE;
        end
      end
      S_TAIL_SECOND: begin
        if (end_second || (slot_free_i && last_item)) begin
          state_d = S_IDLE;
        end
      end
      S_SINGLE: begin
        if (slot_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath updates and emitted items
  always_comb begin
    fc_d        = fc_q;
    sc_d        = sc_q;
    ac_d        = ac_q;
    i_d         = i_q;
    j_d         = j_q;
    z_d         = z_q;
    outcnt_d    = outcnt_q;
    ovf_d       = ovf_q;
    emit_pass_d = emit_pass_q;
    st_d        = st_q;
    wr_o        = '{we_first: 1'b0, we_second: 1'b0, we_anchor: 1'b0,
                    addr: '0, data: value_i};
    emit_o      = '{valid: 1'b0, value: scan_i.elem, last: last_item,
                    status: ST_OK, empty: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_APPEND_FIRST: begin
              wr_o.addr = fc_q[ADDR_W-1:0];
              if (fc_q < CNT_W'(MAX_LEN)) begin
                wr_o.we_first = 1'b1;
                fc_d          = fc_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_APPEND_SECOND: begin
              wr_o.addr = sc_q[ADDR_W-1:0];
              if (sc_q < CNT_W'(MAX_LEN)) begin
                wr_o.we_second = 1'b1;
                sc_d           = sc_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_APPEND_ANCHOR: begin
              wr_o.addr = ac_q[ADDR_W-1:0];
              if (ac_q < CNT_W'(MAX_LEN)) begin
                wr_o.we_anchor = 1'b1;
                ac_d           = ac_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_RUN: begin
              i_d         = '0;
              j_d         = '0;
              z_d         = '0;
              outcnt_d    = '0;
              emit_pass_d = (ac_q == '0);
              st_d        = ovf_q ? ST_OVERFLOW : ST_OK;
            end
            default: ;
          endcase
        end
      end
      S_SCAN_FIRST: begin
        if (end_first) begin
          st_d = ST_MISSING;
        end else if (scan_i.hit) begin
          i_d = i_q + 1'b1;
        end else if (go) begin
          i_d          = i_q + 1'b1;
          emit_o.valid = emit_pass_q;
          outcnt_d     = emit_pass_q ? outcnt_q + 1'b1 : outcnt_q;
        end
      end
      S_SCAN_SECOND: begin
        if (end_second) begin
          st_d = ST_MISSING;
        end else if (scan_i.hit) begin
          j_d = j_q + 1'b1;
          if (!emit_pass_q) begin
            if (last_anchor) begin
              // every anchor found: rewind and walk again, emitting
              i_d         = '0;
              j_d         = '0;
              z_d         = '0;
              emit_pass_d = 1'b1;
            end else begin
              z_d = z_q + 1'b1;
            end
          end
        end else if (go) begin
          j_d          = j_q + 1'b1;
          emit_o.valid = emit_pass_q;
          outcnt_d     = emit_pass_q ? outcnt_q + 1'b1 : outcnt_q;
        end
      end
      S_PUT_ANCHOR: begin
        emit_o.value = anchor_data_i;
        if (slot_free_i) begin
          emit_o.valid = 1'b1;
          z_d          = z_q + 1'b1;
          outcnt_d     = outcnt_q + 1'b1;
        end
      end
      S_TAIL_FIRST: begin
        if (!end_first && slot_free_i) begin
          emit_o.valid = 1'b1;
          i_d          = i_q + 1'b1;
          outcnt_d     = outcnt_q + 1'b1;
        end
      end
      S_TAIL_SECOND: begin
        if (!end_second && slot_free_i) begin
          emit_o.valid = 1'b1;
          j_d          = j_q + 1'b1;
          outcnt_d     = outcnt_q + 1'b1;
        end
      end
      S_SINGLE: begin
        emit_o.value  = '0;
        emit_o.last   = 1'b1;
        emit_o.status = st_q;
        emit_o.empty  = (st_q == ST_OK);
        emit_o.valid  = slot_free_i;
      end
      default: ;
    endcase
    // run finished: lists and overflow flag clear
    if ((state_q != S_IDLE) && (state_d == S_IDLE)) begin
      fc_d  = '0;
      sc_d  = '0;
      ac_d  = '0;
      i_d   = '0;
      j_d   = '0;
      z_d   = '0;
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fc_q        <= '0;
      sc_q        <= '0;
      ac_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      z_q         <= '0;
      outcnt_q    <= '0;
      ovf_q       <= 1'b0;
      emit_pass_q <= 1'b0;
      st_q        <= ST_OK;
    end else begin
      state_q     <= state_d;
      fc_q        <= fc_d;
      sc_q        <= sc_d;
      ac_q        <= ac_d;
      i_q         <= i_d;
      j_q         <= j_d;
      z_q         <= z_d;
      outcnt_q    <= outcnt_d;
      ovf_q       <= ovf_d;
      emit_pass_q <= emit_pass_d;
      st_q        <= st_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.valid |-> slot_free_i)
    else $error("item emitted while result register is full");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fc_q <= CNT_W'(MAX_LEN)) && (sc_q <= CNT_W'(MAX_LEN)) && (ac_q <= CNT_W'(MAX_LEN)))
    else $error("list count beyond capacity");

  a_no_extra_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.valid && (state_q != S_SINGLE)) |-> (emit_pass_q && (outcnt_q < total)))
    else $error("merge emitted more items than it holds");

  a_single_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SINGLE) && slot_free_i) |=> ((state_q == S_IDLE) && (fc_q == '0)))
    else $error("run did not finish after its single item");
`endif

endmodule

>>> tb/asm_merge_checker.sv
// asm_merge_checker: passive scoreboard for anchored_sequence_merge_core
// depends on asm_pkg; watches both channels, predicts merged lists, counts mismatches
`timescale 1ns / 100ps

module asm_merge_checker import asm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [1:0]       op_i,
  input  logic [VAL_W-1:0] value_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [VAL_W-1:0] value_res_i,
  input  logic             last_i,
  input  logic [1:0]       status_i,
  input  logic             empty_res_i,
  output int               outstanding_o,
  output int               fail_count_o
);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
    status_e          status;
    logic             is_empty;
  } merge_item_t;

  // list memories indexed by the append op code
  logic [VAL_W-1:0] list_mem [3][MAX_LEN];
  int               list_len [3];
  bit               overflow_flag;
  logic [VAL_W-1:0] merge_buf [$];
  merge_item_t      merge_q [$];
  int               fails = 0;

  // append one element to the merge buffer
  function automatic void buf_add(input logic [VAL_W-1:0] elem);
    merge_buf.insert(merge_buf.size(), elem);
  endfunction

  // queue one predicted result item
  function automatic void add_result(input logic [VAL_W-1:0] value, input bit last_flag,
                                     input status_e status, input bit is_empty);
    merge_item_t item;
    item.value    = value;
    item.last     = last_flag;
    item.status   = status;
    item.is_empty = is_empty;
    merge_q.insert(merge_q.size(), item);
  endfunction

  // walk one list from pos up to the next match of the anchor, gathering skipped elements
  function automatic bit seek_anchor(input int id, inout int pos,
                                     input logic [VAL_W-1:0] anchor);
    logic [VAL_W-1:0] elem;
    while (pos < list_len[id]) begin
      elem = list_mem[id][pos];
      pos++;
      if (elem == anchor) return 1'b1;
      if (merge_buf.size() < 2 * MAX_LEN) buf_add(elem);
    end
    return 1'b0;
  endfunction

  function automatic void predict_merge();
    int fpos;
    int spos;
    int z;
    int k;
    bit found;
    fpos = 0;
    spos = 0;
    found = 1'b1;
    merge_buf.delete();
    if (overflow_flag) begin
      add_result('0, 1'b1, ST_OVERFLOW, 1'b0);
    end else begin
      for (z = 0; z < list_len[OP_APPEND_ANCHOR] && found; z++) begin
        found = seek_anchor(OP_APPEND_FIRST, fpos, list_mem[OP_APPEND_ANCHOR][z]) &&
                seek_anchor(OP_APPEND_SECOND, spos, list_mem[OP_APPEND_ANCHOR][z]);
        if (found && merge_buf.size() < 2 * MAX_LEN)
          buf_add(list_mem[OP_APPEND_ANCHOR][z]);
      end
      if (!found) begin
        add_result('0, 1'b1, ST_MISSING, 1'b0);
      end else begin
        for (; fpos < list_len[OP_APPEND_FIRST] && merge_buf.size() < 2 * MAX_LEN; fpos++)
          buf_add(list_mem[OP_APPEND_FIRST][fpos]);
        for (; spos < list_len[OP_APPEND_SECOND] && merge_buf.size() < 2 * MAX_LEN; spos++)
          buf_add(list_mem[OP_APPEND_SECOND][spos]);
        if (merge_buf.size() == 0) begin
          add_result('0, 1'b1, ST_OK, 1'b1);
        end else begin
          for (k = 0; k < merge_buf.size(); k++)
            add_result(merge_buf[k], (k == merge_buf.size() - 1), ST_OK, 1'b0);
        end
      end
    end
    list_len = '{0, 0, 0};
    overflow_flag = 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    merge_item_t want;
    if (!rst_ni) begin
      list_len = '{0, 0, 0};
      overflow_flag = 1'b0;
      merge_q.delete();
      outstanding_o <= 0;
      fail_count_o <= fails;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (merge_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value_res %h last %b",
                   $time, value_res_i, last_i, " status %0d empty_res %b",
                   status_i, empty_res_i);
          fails++;
        end else begin
          want = merge_q.pop_front();
          if (value_res_i !== want.value) begin
            $display("%0t: value_res expected %h actual %h", $time, want.value, value_res_i);
            fails++;
          end
          if (last_i !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, last_i);
            fails++;
          end
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
            fails++;
          end
          if (empty_res_i !== want.is_empty) begin
            $display("%0t: empty_res expected %b actual %b", $time, want.is_empty,
                     empty_res_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (op_i == OP_RUN) begin
          predict_merge();
        end else if (list_len[op_i] < MAX_LEN) begin
          list_mem[op_i][list_len[op_i]] = value_i;
          list_len[op_i]++;
        end else begin
          overflow_flag = 1'b1;
        end
      end
      outstanding_o <= merge_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

>>> tb/anchored_sequence_merge_core_tb.sv
// anchored_sequence_merge_core_tb: stimulus and verdict for anchored_sequence_merge_core
// depends on asm_pkg, the core and asm_merge_checker, which checks every result
`timescale 1ns / 100ps

module anchored_sequence_merge_core_tb;
  import asm_pkg::*;

  // stall stretch of the receiver while the sender keeps offering loads
  localparam int HOLD_CYCLES  = 400;
  // cycles without any transfer before the run is declared hung; covers the
  // hold above, a full check pass and long random stalls
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {
    SEQ_WELL,
    SEQ_NOISE,
    SEQ_EMPTY,
    SEQ_OVERFLOW,
    SEQ_FULL
  } seq_kind_e;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [1:0]       op_i;
  logic [VAL_W-1:0] value_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [VAL_W-1:0] value_res_o;
  logic             last_o;
  logic [1:0]       status_o;
  logic             empty_res_o;

  int outstanding;
  int fail_count;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  // per-list load queues of the sequence being built
  logic [VAL_W-1:0] first_q [$];
  logic [VAL_W-1:0] second_q [$];
  logic [VAL_W-1:0] anchor_q [$];

  anchored_sequence_merge_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_res_o (value_res_o),
    .last_o      (last_o),
    .status_o    (status_o),
    .empty_res_o (empty_res_o)
  );

  asm_merge_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .op_i          (op_i),
    .value_i       (value_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_res_i   (value_res_o),
    .last_i        (last_o),
    .status_i      (status_o),
    .empty_res_i   (empty_res_o),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog: counts cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("anchored_sequence_merge_core verification failed");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request, counted here
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // value mix: extremes and walking bits often, full-range random otherwise
  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] bitpos;
    bitpos = '0;
    bitpos[$urandom_range(VAL_W - 1)] = 1'b1;
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return bitpos;
      3:       return ~bitpos;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // one transfer; valid stays high from offer to acceptance, and is only lowered
  // by the idle gap of the next call or by the end of stimulus
  task automatic send_item(input op_e op, input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    value_i <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // build three load lists for one merge, send them interleaved, then run
  task automatic run_sequence(input seq_kind_e kind);
    logic [VAL_W-1:0] pool [8];
    logic [VAL_W-1:0] anchor;
    int pool_n;
    int z;
    int pick;
    pool_n = $urandom_range(2, 6);
    for (z = 0; z < 8; z++) pool[z] = pick_value();
    case (kind)
      SEQ_WELL: begin
        // every anchor is placed in order in both lists, so the merge always succeeds;
        // fillers come from a small pool so repeated values and early matches occur
        repeat ($urandom_range(4)) begin
          anchor = pool[$urandom_range(pool_n - 1)];
          repeat ($urandom_range(3))
            first_q.insert(first_q.size(), pool[$urandom_range(pool_n - 1)]);
          first_q.insert(first_q.size(), anchor);
          repeat ($urandom_range(3))
            second_q.insert(second_q.size(), pool[$urandom_range(pool_n - 1)]);
          second_q.insert(second_q.size(), anchor);
          anchor_q.insert(anchor_q.size(), anchor);
        end
        repeat ($urandom_range(3))
          first_q.insert(first_q.size(), pool[$urandom_range(pool_n - 1)]);
        repeat ($urandom_range(3))
          second_q.insert(second_q.size(), pool[$urandom_range(pool_n - 1)]);
      end
      SEQ_NOISE: begin
        // unrelated lists: anchors found or missing by chance
        repeat ($urandom_range(5))
          first_q.insert(first_q.size(), pool[$urandom_range(pool_n - 1)]);
        repeat ($urandom_range(5))
          second_q.insert(second_q.size(), pool[$urandom_range(pool_n - 1)]);
        repeat ($urandom_range(4))
          anchor_q.insert(anchor_q.size(), pool[$urandom_range(pool_n - 1)]);
      end
      SEQ_OVERFLOW: begin
        // one list past capacity; the overflow item must win over any anchor check
        pick = $urandom_range(2);
        repeat (MAX_LEN + 1 + $urandom_range(2)) begin
          case (pick)
            0:       first_q.insert(first_q.size(), pick_value());
            1:       second_q.insert(second_q.size(), pick_value());
            default: anchor_q.insert(anchor_q.size(), pick_value());
          endcase
        end
        repeat ($urandom_range(2)) anchor_q.insert(anchor_q.size(), pick_value());
      end
      SEQ_FULL: begin
        // both lists at capacity, no anchors: the longest possible merge
        repeat (MAX_LEN) first_q.insert(first_q.size(), pick_value());
        repeat (MAX_LEN) second_q.insert(second_q.size(), pick_value());
      end
      default: ;
    endcase
    while (first_q.size() + second_q.size() + anchor_q.size() > 0) begin
      pick = $urandom_range(2);
      if (pick == 0 && first_q.size() > 0)
        send_item(OP_APPEND_FIRST, first_q.pop_front());
      else if (pick == 1 && second_q.size() > 0)
        send_item(OP_APPEND_SECOND, second_q.pop_front());
      else if (pick == 2 && anchor_q.size() > 0)
        send_item(OP_APPEND_ANCHOR, anchor_q.pop_front());
    end
    send_item(OP_RUN, pick_value());
  endtask

  function automatic seq_kind_e random_kind();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return SEQ_WELL;
    if (roll < 85) return SEQ_NOISE;
    if (roll < 92) return SEQ_EMPTY;
    if (roll < 97) return SEQ_OVERFLOW;
    return SEQ_FULL;
  endfunction

  initial begin
    int phase_idle [4];
    int phase_stall [4];
    int phase_end [4];
    int ph;
    phase_idle = '{0, 71, 0, 30};
    phase_stall = '{0, 0, 71, 30};
    phase_end = '{135, 250, 365, 470};
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OP_APPEND_FIRST;
    value_i = '0;
    out_ready_i = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: run on nothing gives the empty item
    send_item(OP_RUN, '0);
    // extremes of the value field around a single anchor of zero
    send_item(OP_APPEND_FIRST, '1);
    send_item(OP_APPEND_FIRST, 31'd5);
    send_item(OP_APPEND_FIRST, '0);
    send_item(OP_APPEND_SECOND, 31'h2aaa_aaaa);
    send_item(OP_APPEND_SECOND, '0);
    send_item(OP_APPEND_SECOND, 31'h5555_5555);
    send_item(OP_APPEND_ANCHOR, '0);
    send_item(OP_RUN, '1);
    // anchor present in the first list but missing from the second
    send_item(OP_APPEND_ANCHOR, 31'd3);
    send_item(OP_APPEND_FIRST, 31'd3);
    send_item(OP_APPEND_SECOND, 31'd4);
    send_item(OP_RUN, '0);
    // repeated values: each search resumes after the previous match
    send_item(OP_APPEND_FIRST, 31'd1);
    send_item(OP_APPEND_FIRST, 31'd1);
    send_item(OP_APPEND_FIRST, 31'd2);
    send_item(OP_APPEND_SECOND, 31'd1);
    send_item(OP_APPEND_SECOND, 31'd2);
    send_item(OP_APPEND_SECOND, 31'd1);
    send_item(OP_APPEND_ANCHOR, 31'd1);
    send_item(OP_APPEND_ANCHOR, 31'd1);
    send_item(OP_RUN, '0);

    // capacity cases once up front: full lists, then a dropped load
    run_sequence(SEQ_FULL);
    run_sequence(SEQ_OVERFLOW);
    // long receiver hold-off while loads keep coming; the run stalls the input
    hold_req = 1'b1;
    run_sequence(SEQ_WELL);
    run_sequence(SEQ_WELL);

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      while (items_sent < phase_end[ph]) run_sequence(random_kind());
    end
    in_valid_i <= 1'b0;

    // the checker's count is registered, so it lags the last transfer
    repeat (2) @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("anchored_sequence_merge_core verification clean");
    end else begin
      $display("anchored_sequence_merge_core verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/asm_pkg.sv
rtl/asm_ram.sv
rtl/asm_scan_unit.sv
rtl/asm_seq.sv
rtl/anchored_sequence_merge_core.sv
tb/asm_merge_checker.sv
tb/anchored_sequence_merge_core_tb.sv
